[src/nfd_pkg.sv]
// Shared types and constants of the notification frame decoder.
`default_nettype none

package nfd_pkg;

    // Frame store geometry
    localparam int unsigned STORE_DEPTH = 18;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

    // Configuration register indexes, also the priority order of the code match
    localparam int unsigned NUM_CODES = 7;
    localparam int unsigned CFG_AW    = $clog2(NUM_CODES);
    localparam logic [CFG_AW-1:0] CFG_BATTERY = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_POWER   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PITCH   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ROLL    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PAN     = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_MODE    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_KEY     = 3'd6;

    // Frame status codes
    localparam logic [2:0] STAT_CMD_OK      = 3'd0;
    localparam logic [2:0] STAT_CMD_UNKNOWN = 3'd1;
    localparam logic [2:0] STAT_CMD_CRC_BAD = 3'd2;
    localparam logic [2:0] STAT_WHEEL_OK    = 3'd3;
    localparam logic [2:0] STAT_WHEEL_BAD   = 3'd4;
    localparam logic [2:0] STAT_KEY         = 3'd5;
    localparam logic [2:0] STAT_UNRECOG     = 3'd6;

    // Header bytes
    localparam logic [7:0] HDR_CMD     = 8'h06;
    localparam logic [7:0] HDR_WHEEL_0 = 8'h24;
    localparam logic [7:0] HDR_WHEEL_1 = 8'h3E;
    localparam logic [7:0] HDR_WHEEL_2 = 8'h0C;
    localparam logic [7:0] HDR_KEY_0   = 8'hC0;
    localparam logic [7:0] HDR_KEY_1   = 8'h20;
    localparam logic [7:0] HDR_KEY_2   = 8'h00;

    // Last positions (length minus one) of the three frame kinds
    localparam logic [7:0] POS_KEY_LAST   = 8'd3;
    localparam logic [7:0] POS_CMD_LAST   = 8'd6;
    localparam logic [7:0] POS_WHEEL_LAST = 8'd17;

    typedef logic [NUM_CODES-1:0][15:0] nfd_codes_t;

    // Capture state seen by the decoder
    typedef struct packed {
        logic [7:0]                  pos;
        logic [STORE_DEPTH-1:0][7:0] store;
        logic [15:0]                 crc_short;
        logic [15:0]                 crc_long;
    } nfd_view_t;

    // One result item
    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        battery;
        logic [15:0]        power;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] pan;
        logic [15:0]        mode;
        logic [15:0]        key;
        logic [7:0]         wheel_mode;
        logic [7:0]         wheel_status;
        logic signed [7:0]  wheel_value;
        logic               link;
    } nfd_result_t;

endpackage

`default_nettype wire

[src/notification_frame_decoder.sv]
// Top level of the notification frame decoder: configuration, output register.
//
// Usage:
//   Bytes of a notification enter on the s_ channel, one request per byte, with
//   s_tlast on the final byte. Each notification gives exactly one result on
//   the m_ channel: the frame status in m_tuser and all held readings in m_tdata.
//   Non-final bytes give no result.
//   Latency: the result is valid in the cycle after the final byte is taken.
//   Throughput: one byte per cycle while s_tready is high; the CRC step and the
//   classification of the finished frame are combinational logic between the
//   capture registers and the output register.
//   Stall: s_tready follows the output register; it stays high while the
//   output register is empty or being taken, so a stalled receiver holds the
//   input off after one result waits.
//   Configuration: cfg_wr_en writes the command code at cfg_wr_addr on the
//   clock edge; indexes past the last code are ignored. Write only when idle.
//   Reset: aresetn (synchronous, active low) clears the byte counter, the CRC
//   accumulators, the codes, the held readings and the output valid at once.
`default_nettype none

module notification_frame_decoder (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Input bytes
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  wire logic                       s_tlast,   // last_byte
    // Results
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [15:0] battery_centivolts, [31:16] power_state, [47:32] pitch_centideg,
    // [63:48] roll_centideg, [79:64] pan_centideg, [95:80] gimbal_mode,
    // [111:96] key_code, [119:112] wheel_mode, [127:120] wheel_status,
    // [135:128] wheel_value, [136] link_seen, [143:137] zero
    output logic [143:0]                    m_tdata,
    output logic [2:0]                      m_tuser,   // [2:0] frame_status
    // Configuration writes
    input  wire logic                       cfg_wr_en,
    input  wire logic [nfd_pkg::CFG_AW-1:0] cfg_wr_addr,
    input  wire logic [15:0]                cfg_wr_data
);

    nfd_pkg::nfd_codes_t  codes_reg;
    nfd_pkg::nfd_view_t   view;
    nfd_pkg::nfd_result_t result;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [143:0] m_tdata_reg;
    logic [2:0]   m_tuser_reg;
    logic         byte_acc, frame_end;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign byte_acc  = s_tvalid && s_tready;
    assign frame_end = byte_acc && s_tlast;

    // Command code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg <= '0;
        end else if (cfg_wr_en && cfg_wr_addr < nfd_pkg::CFG_AW'(nfd_pkg::NUM_CODES)) begin
            codes_reg[cfg_wr_addr] <= cfg_wr_data;
        end
    end

    nfd_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_acc  (byte_acc),
        .byte_in   (s_tdata),
        .byte_last (s_tlast),
        .view      (view)
    );

    nfd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frame_end (frame_end),
        .byte_in   (s_tdata),
        .view      (view),
        .codes     (codes_reg),
        .result    (result)
    );

    // Output valid: set by a finished frame, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (frame_end) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge aclk) begin
        if (frame_end) begin
            m_tuser_reg <= result.status;
            m_tdata_reg <= {7'd0, result.link, result.wheel_value, result.wheel_status,
                            result.wheel_mode, result.key, result.mode, result.pan,
                            result.roll, result.pitch, result.power, result.battery};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A new result only follows an accepted final byte
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result raised without a final byte");

    // A non-final byte never leaves a result pending
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid_reg)
        else $error("result pending after a non-final byte");

    // Status within the defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_tuser_reg <= nfd_pkg::STAT_UNRECOG)
        else $error("frame status out of range");

    // Every result reports the link as seen
    a_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_tdata_reg[136])
        else $error("result without link flag");

    // Output valid is low after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");

endmodule

`default_nettype wire

[src/nfd_capture.sv]
// Byte position counter, frame store and running CRC-16/XMODEM accumulators.
`default_nettype none

module nfd_capture (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          byte_acc,
    input  wire logic [7:0]    byte_in,
    input  wire logic          byte_last,
    output nfd_pkg::nfd_view_t view
);

    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_short_reg, crc_short_next;
    logic [15:0] crc_long_reg, crc_long_next;
    logic [nfd_pkg::STORE_DEPTH-1:0][7:0] store_reg;

    // Bytewise CRC update, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Advance count and accumulators; clear them at the end of a notification
    always_comb begin
        count_next     = count_reg;
        crc_short_next = crc_short_reg;
        crc_long_next  = crc_long_reg;
        if (byte_acc) begin
            if (byte_last) begin
                count_next     = 8'd0;
                crc_short_next = 16'd0;
                crc_long_next  = 16'd0;
            end else begin
                if (count_reg != 8'hFF) begin
                    count_next = count_reg + 8'd1;
                end
                if (count_reg < 8'd5) begin
                    crc_short_next = crc_byte(crc_short_reg, byte_in);
                end
                if (count_reg >= 8'd3 && count_reg <= 8'd15) begin
                    crc_long_next = crc_byte(crc_long_reg, byte_in);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= 8'd0;
            crc_short_reg <= 16'd0;
            crc_long_reg  <= 16'd0;
        end else begin
            count_reg     <= count_next;
            crc_short_reg <= crc_short_next;
            crc_long_reg  <= crc_long_next;
        end
    end

    // Store the byte at its position; bytes past the store are dropped
    always_ff @(posedge aclk) begin
        if (byte_acc && count_reg < 8'(nfd_pkg::STORE_DEPTH)) begin
            store_reg[count_reg[nfd_pkg::STORE_AW-1:0]] <= byte_in;
        end
    end

    assign view.pos       = count_reg;
    assign view.store     = store_reg;
    assign view.crc_short = crc_short_reg;
    assign view.crc_long  = crc_long_reg;

endmodule

`default_nettype wire

[src/nfd_decode.sv]
// Frame classification, command code match and held readings.
`default_nettype none

module nfd_decode (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                frame_end,
    input  wire logic [7:0]          byte_in,
    input  wire nfd_pkg::nfd_view_t  view,
    input  wire nfd_pkg::nfd_codes_t codes,
    output nfd_pkg::nfd_result_t     result
);

    logic [15:0] battery_reg, battery_next;
    logic [15:0] power_reg, power_next;
    logic [15:0] pitch_reg, pitch_next;
    logic [15:0] roll_reg, roll_next;
    logic [15:0] pan_reg, pan_next;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] key_reg, key_next;
    logic [7:0]  wmode_reg, wmode_next;
    logic [7:0]  wstat_reg, wstat_next;
    logic [7:0]  wval_reg, wval_next;

    logic [2:0]  status;
    logic        is_cmd, is_wheel, is_key;
    logic [15:0] cmd_code, cmd_val;
    logic        hit;
    logic [nfd_pkg::CFG_AW-1:0] hit_sel;

    // Recognise the frame kind; the final byte comes straight from the input
    assign is_cmd   = view.pos == nfd_pkg::POS_CMD_LAST && view.store[0] == nfd_pkg::HDR_CMD;
    assign is_wheel = view.pos == nfd_pkg::POS_WHEEL_LAST
                   && view.store[0] == nfd_pkg::HDR_WHEEL_0
                   && view.store[1] == nfd_pkg::HDR_WHEEL_1
                   && view.store[2] == nfd_pkg::HDR_WHEEL_2;
    assign is_key   = view.pos == nfd_pkg::POS_KEY_LAST
                   && view.store[0] == nfd_pkg::HDR_KEY_0
                   && view.store[1] == nfd_pkg::HDR_KEY_1
                   && view.store[2] == nfd_pkg::HDR_KEY_2;
    assign cmd_code = {view.store[1], view.store[2]};
    assign cmd_val  = {view.store[3], view.store[4]};

    // First matching code wins
    always_comb begin
        hit     = 1'b0;
        hit_sel = nfd_pkg::CFG_BATTERY;
        for (int k = nfd_pkg::NUM_CODES - 1; k >= 0; k--) begin
            if (cmd_code == codes[k]) begin
                hit     = 1'b1;
                hit_sel = nfd_pkg::CFG_AW'(k);
            end
        end
    end

    // Work out the status and the readings after this frame
    always_comb begin
        battery_next = battery_reg;
        power_next   = power_reg;
        pitch_next   = pitch_reg;
        roll_next    = roll_reg;
        pan_next     = pan_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        wmode_next   = wmode_reg;
        wstat_next   = wstat_reg;
        wval_next    = wval_reg;
        status       = nfd_pkg::STAT_UNRECOG;
        if (is_cmd) begin
            if (view.crc_short != {view.store[5], byte_in}) begin
                status = nfd_pkg::STAT_CMD_CRC_BAD;
            end else if (!hit) begin
                status = nfd_pkg::STAT_CMD_UNKNOWN;
            end else begin
                status = nfd_pkg::STAT_CMD_OK;
                case (hit_sel)
                    nfd_pkg::CFG_BATTERY: battery_next = cmd_val;
                    nfd_pkg::CFG_POWER:   power_next   = cmd_val;
                    nfd_pkg::CFG_PITCH:   pitch_next   = cmd_val;
                    nfd_pkg::CFG_ROLL:    roll_next    = cmd_val;
                    nfd_pkg::CFG_PAN:     pan_next     = cmd_val;
                    nfd_pkg::CFG_MODE:    mode_next    = cmd_val;
                    default:              key_next     = cmd_val;
                endcase
            end
        end else if (is_wheel) begin
            if (view.crc_long == {byte_in, view.store[16]}) begin
                status     = nfd_pkg::STAT_WHEEL_OK;
                wmode_next = view.store[10];
                wstat_next = view.store[11];
                wval_next  = view.store[12];
            end else begin
                status = nfd_pkg::STAT_WHEEL_BAD;
            end
        end else if (is_key) begin
            status   = nfd_pkg::STAT_KEY;
            key_next = {8'h00, byte_in};
        end
    end

    // Hold the readings; update only at the end of a notification
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            battery_reg <= 16'd0;
            power_reg   <= 16'd0;
            pitch_reg   <= 16'd0;
            roll_reg    <= 16'd0;
            pan_reg     <= 16'd0;
            mode_reg    <= 16'd0;
            key_reg     <= 16'd0;
            wmode_reg   <= 8'd0;
            wstat_reg   <= 8'd0;
            wval_reg    <= 8'd0;
        end else if (frame_end) begin
            battery_reg <= battery_next;
            power_reg   <= power_next;
            pitch_reg   <= pitch_next;
            roll_reg    <= roll_next;
            pan_reg     <= pan_next;
            mode_reg    <= mode_next;
            key_reg     <= key_next;
            wmode_reg   <= wmode_next;
            wstat_reg   <= wstat_next;
            wval_reg    <= wval_next;
        end
    end

    assign result.status       = status;
    assign result.battery      = battery_next;
    assign result.power        = power_next;
    assign result.pitch        = pitch_next;
    assign result.roll         = roll_next;
    assign result.pan          = pan_next;
    assign result.mode         = mode_next;
    assign result.key          = key_next;
    assign result.wheel_mode   = wmode_next;
    assign result.wheel_status = wstat_next;
    assign result.wheel_value  = wval_next;
    assign result.link         = 1'b1;

endmodule

`default_nettype wire
